[rtl/core/rflc_pkg.sv]
// ----------------------------------------------------------------------------
// rflc_pkg: shared types and constants of the reflectance line classifier
// Window geometry, register map, color codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rflc_pkg;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned WIN_IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned WIN_CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam logic [WIN_IDX_W-1:0] WIN_LAST = WIN_IDX_W'(WINDOW_DEPTH - 1);

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned COLOR_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  localparam logic [SAMPLE_W-1:0] THR_BLACK_RST   = 10'd40;
  localparam logic [SAMPLE_W-1:0] THR_WHITE_RST   = 10'd120;
  localparam logic [GAIN_W-1:0]   GAIN_NEW_RST    = 16'd16384;
  localparam logic [GAIN_W-1:0]   GAIN_PREV_RST   = 16'd16384;
  localparam logic [SAMPLE_W-1:0] MAX_REFLECT_RST = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_BLACK   = 3'd0,
    REG_THR_WHITE   = 3'd1,
    REG_GAIN_NEW    = 3'd2,
    REG_GAIN_PREV   = 3'd3,
    REG_MAX_REFLECT = 3'd4
  } cfg_reg_e;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_BLACK = 2'd0,
    COLOR_GRAY  = 2'd1,
    COLOR_WHITE = 2'd2
  } line_color_e;

endpackage

`default_nettype wire

[rtl/core/reflectance_filter_line_classifier_unit.sv]
// ----------------------------------------------------------------------------
// reflectance_filter_line_classifier_unit: brightness, low-pass, window class
// Converts a color sample to brightness, stores it in the sample window RAM,
// runs a first-order low-pass filter and classifies the window contents.
// ----------------------------------------------------------------------------
// Flow: a taken request steps through WRITE, MULB, SCAN, DRAIN and DONE; the
//   next is taken after the result is loaded. The window scan reads one RAM
//   entry per cycle through the single read port.
// Reset: registers take their reset values, window reads as zero through
//   per-entry valid bits, write slot and filter state cleared, no sweep.
`default_nettype none

module reflectance_filter_line_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rflc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rflc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rflc_pkg::SAMPLE_W-1:0]   red_raw_i,
  input  logic [rflc_pkg::SAMPLE_W-1:0]   green_raw_i,
  input  logic [rflc_pkg::SAMPLE_W-1:0]   blue_raw_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rflc_pkg::SAMPLE_W-1:0]   brightness_o,
  output logic [rflc_pkg::LEVEL_W-1:0]    filtered_level_o,
  output logic [rflc_pkg::COLOR_W-1:0]    line_color_o
);
  import rflc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRITE = 6'b000010,
    S_MULB  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [SAMPLE_W-1:0] thr_black_q, thr_white_q, max_reflect_q;
  logic [GAIN_W-1:0]   gain_new_q, gain_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_black_q   <= THR_BLACK_RST;
      thr_white_q   <= THR_WHITE_RST;
      gain_new_q    <= GAIN_NEW_RST;
      gain_prev_q   <= GAIN_PREV_RST;
      max_reflect_q <= MAX_REFLECT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_THR_BLACK:   thr_black_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_THR_WHITE:   thr_white_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_GAIN_NEW:    gain_new_q    <= cfg_wdata_i;
        REG_GAIN_PREV:   gain_prev_q   <= cfg_wdata_i;
        REG_MAX_REFLECT: max_reflect_q <= cfg_wdata_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  logic in_req, out_req, out_load;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_req     = in_valid_i && !in_stall_o;
  assign out_req    = out_valid_o && !out_stall_i;
  assign out_load   = (state_q == S_DONE) && (!out_valid_o || !out_stall_i);

  // brightness: floor((g+b)/2) clamped
  logic [SAMPLE_W:0]   gb_sum;
  logic [SAMPLE_W-1:0] bright_raw, bright_d;
  assign gb_sum     = {1'b0, green_raw_i} + {1'b0, blue_raw_i};
  assign bright_raw = gb_sum[SAMPLE_W:1];
  assign bright_d   = (bright_raw > max_reflect_q) ? max_reflect_q : bright_raw;

  logic [SAMPLE_W-1:0] bright_q;
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      bright_q <= bright_d;
    end
  end

  // sequencer
  logic [WIN_IDX_W-1:0] slot_q, scan_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_req) state_d = S_WRITE;
      S_WRITE: state_d = S_MULB;
      S_MULB:  state_d = S_SCAN;
      S_SCAN:  if (scan_q == WIN_LAST) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_WRITE) begin
        slot_q <= (slot_q == WIN_LAST) ? '0 : slot_q + 1'b1;
      end
      if (state_q == S_MULB) begin
        scan_q <= '0;
      end else if (state_q == S_SCAN) begin
        scan_q <= (scan_q == WIN_LAST) ? '0 : scan_q + 1'b1;
      end
    end
  end

  // sample window RAM, one write and one registered read port
  logic [SAMPLE_W-1:0]     win_mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0]     rd_data_q;
  logic [WINDOW_DEPTH-1:0] win_vld_q;
  logic                    rd_vld_q, cnt_en_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      win_mem[slot_q] <= bright_q;
    end
    if (state_q == S_SCAN) begin
      rd_data_q <= win_mem[scan_q];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      cnt_en_q  <= 1'b0;
    end else begin
      if (state_q == S_WRITE) begin
        win_vld_q[slot_q] <= 1'b1;
      end
      if (state_q == S_SCAN) begin
        rd_vld_q <= win_vld_q[scan_q];
      end
      cnt_en_q <= (state_q == S_SCAN);
    end
  end

  // window classification counters
  logic [SAMPLE_W-1:0]  sample;
  logic                 is_black, is_white, is_gray;
  logic [WIN_CNT_W-1:0] blacks_q, whites_q, grays_q;

  assign sample   = rd_vld_q ? rd_data_q : '0;
  assign is_black = (sample < thr_black_q);
  assign is_white = !is_black && (sample > thr_white_q);
  assign is_gray  = !is_black && !is_white &&
                    (sample > thr_black_q) && (sample < thr_white_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MULB) begin
      blacks_q <= '0;
      whites_q <= '0;
      grays_q  <= '0;
    end else if (cnt_en_q) begin
      blacks_q <= blacks_q + WIN_CNT_W'(is_black);
      whites_q <= whites_q + WIN_CNT_W'(is_white);
      grays_q  <= grays_q + WIN_CNT_W'(is_gray);
    end
  end

  // low-pass filter: two products on separate cycles, then sum and saturate
  logic [GAIN_W+SAMPLE_W-1:0] prod_a_q;
  logic [GAIN_W+LEVEL_W-1:0]  prod_b_q;
  logic [GAIN_W+LEVEL_W:0]    acc;
  logic [GAIN_W+LEVEL_W-15:0] acc_sh;
  logic [LEVEL_W-1:0]         level_d, prev_q;

  assign acc    = {(LEVEL_W - SAMPLE_W + 1)'(0), prod_a_q} + {1'b0, prod_b_q};
  assign acc_sh = acc[GAIN_W+LEVEL_W:15];
  assign level_d = (acc_sh > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : acc_sh[LEVEL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      prod_a_q <= gain_new_q * bright_q;
    end
    if (state_q == S_MULB) begin
      prod_b_q <= gain_prev_q * prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if ((state_q == S_SCAN) && (scan_q == '0)) begin
      prev_q <= level_d;
    end
  end

  // decision and output register
  line_color_e color_d;
  always_comb begin
    if (whites_q == WIN_CNT_W'(WINDOW_DEPTH)) begin
      color_d = COLOR_WHITE;
    end else if (blacks_q > grays_q) begin
      color_d = COLOR_BLACK;
    end else begin
      color_d = COLOR_GRAY;
    end
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_req) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [SAMPLE_W-1:0] out_bright_q;
  logic [LEVEL_W-1:0]  out_level_q;
  line_color_e         out_color_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bright_q <= bright_q;
      out_level_q  <= prev_q;
      out_color_q  <= color_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign brightness_o     = out_bright_q;
  assign filtered_level_o = out_level_q;
  assign line_color_o     = out_color_q;

endmodule

`default_nettype wire

[rtl/core/rflc_checker.sv]
// ----------------------------------------------------------------------------
// rflc_checker: port-level checks of the reflectance line classifier
// Watches request ordering, result encoding and stalled-result hold on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rflc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [rflc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [rflc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [rflc_pkg::SAMPLE_W-1:0]   red_raw_i,
  input logic [rflc_pkg::SAMPLE_W-1:0]   green_raw_i,
  input logic [rflc_pkg::SAMPLE_W-1:0]   blue_raw_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rflc_pkg::SAMPLE_W-1:0]   brightness_o,
  input logic [rflc_pkg::LEVEL_W-1:0]    filtered_level_o,
  input logic [rflc_pkg::COLOR_W-1:0]    line_color_o
);
  import rflc_pkg::*;

  // one request at a time: busy right after a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  // a new result only comes out of a busy phase
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  a_color_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_color_o == COLOR_BLACK || line_color_o == COLOR_GRAY ||
                     line_color_o == COLOR_WHITE))
    else $error("illegal line color code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(brightness_o) &&
                                   $stable(filtered_level_o) && $stable(line_color_o))
    else $error("stalled result changed");

endmodule

bind reflectance_filter_line_classifier_unit rflc_checker u_rflc_checker (.*);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for reflectance_filter_line_classifier_unit
// Drives color samples over a valid/stall request channel and holds its own
// model of the brightness clamp, the Q1.15 low-pass and the window
// classification. Each result is checked field by field against the oldest
// pending prediction. Register settings change between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rflc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 107;
  localparam int unsigned SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(REG_MAX_REFLECT + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] brightness;
    logic [LEVEL_W-1:0]  level;
    line_color_e         color;
  } reading_t;

  // brightness region that a run of random samples aims at
  typedef enum int {
    LVL_ANY,
    LVL_BLACK,
    LVL_AT_BLACK,
    LVL_GRAY,
    LVL_AT_WHITE,
    LVL_WHITE,
    LVL_AT_CLAMP
  } level_pick_e;

  class reflect_scoreboard;
    logic [SAMPLE_W-1:0] thr_black;
    logic [SAMPLE_W-1:0] thr_white;
    logic [GAIN_W-1:0]   wt_new;
    logic [GAIN_W-1:0]   wt_prev;
    logic [SAMPLE_W-1:0] clamp;
    logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
    int unsigned         slot;
    logic [LEVEL_W-1:0]  filt_level;
    reading_t            expected_readings [$];
    int unsigned         errors;

    function new();
      thr_black  = THR_BLACK_RST;
      thr_white  = THR_WHITE_RST;
      wt_new     = GAIN_NEW_RST;
      wt_prev    = GAIN_PREV_RST;
      clamp      = MAX_REFLECT_RST;
      foreach (ring[k]) ring[k] = '0;
      slot       = 0;
      filt_level = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THR_BLACK:   thr_black = data[SAMPLE_W-1:0];
        REG_THR_WHITE:   thr_white = data[SAMPLE_W-1:0];
        REG_GAIN_NEW:    wt_new    = data[GAIN_W-1:0];
        REG_GAIN_PREV:   wt_prev   = data[GAIN_W-1:0];
        REG_MAX_REFLECT: clamp     = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    function line_color_e classify();
      int unsigned blacks, whites, grays;
      blacks = 0;
      whites = 0;
      grays  = 0;
      foreach (ring[k]) begin
        if (ring[k] < thr_black) blacks++;
        else if (ring[k] > thr_white) whites++;
        else if (ring[k] > thr_black && ring[k] < thr_white) grays++;
      end
      if (whites == WINDOW_DEPTH) return COLOR_WHITE;
      return (blacks > grays) ? COLOR_BLACK : COLOR_GRAY;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] green, logic [SAMPLE_W-1:0] blue);
      logic [SAMPLE_W:0]   sum;
      logic [SAMPLE_W-1:0] bright;
      logic [47:0]         acc;
      reading_t            r;
      sum    = {1'b0, green} + {1'b0, blue};
      bright = sum[SAMPLE_W:1];
      if (bright > clamp) bright = clamp;
      ring[slot] = bright;
      slot = (slot + 1) % WINDOW_DEPTH;
      acc = 48'(wt_new) * 48'(bright) + 48'(wt_prev) * 48'(filt_level);
      acc = acc >> 15;
      filt_level = (acc > 48'(LEVEL_MAX)) ? LEVEL_MAX : acc[LEVEL_W-1:0];
      r.brightness = bright;
      r.level      = filt_level;
      r.color      = classify();
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic [SAMPLE_W-1:0] bright, logic [LEVEL_W-1:0] lvl,
                                logic [COLOR_W-1:0] color);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        $display("%0t: result with no pending request: brightness %0d level %0d color %0d",
                 $time, bright, lvl, color);
        errors++;
        return;
      end
      exp_r = expected_readings.pop_front();
      if (bright !== exp_r.brightness) begin
        $display("%0t: brightness expected %0d actual %0d", $time, exp_r.brightness, bright);
        errors++;
      end
      if (lvl !== exp_r.level) begin
        $display("%0t: filtered_level expected %0d actual %0d", $time, exp_r.level, lvl);
        errors++;
      end
      if (color !== exp_r.color) begin
        $display("%0t: line_color expected %0d actual %0d", $time, exp_r.color, color);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_readings.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   red_raw     = '0;
  logic [SAMPLE_W-1:0]   green_raw   = '0;
  logic [SAMPLE_W-1:0]   blue_raw    = '0;
  logic                  out_valid_o;
  logic                  out_stall   = 1'b0;
  logic [SAMPLE_W-1:0]   brightness_o;
  logic [LEVEL_W-1:0]    filtered_level_o;
  logic [COLOR_W-1:0]    line_color_o;

  bit quiet_tail = 1'b0;
  bit gaps_on    = 1'b1;

  reflect_scoreboard sb = new();

  reflectance_filter_line_classifier_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .red_raw_i        (red_raw),
    .green_raw_i      (green_raw),
    .blue_raw_i       (blue_raw),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .brightness_o     (brightness_o),
    .filtered_level_o (filtered_level_o),
    .line_color_o     (line_color_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // returns at the edge where the request was taken; valid stays high
  task automatic send_sample(input logic [SAMPLE_W-1:0] r, g, b);
    if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    red_raw   <= r;
    green_raw <= g;
    blue_raw  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(g, b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_settings(input logic [CFG_DATA_W-1:0] d_black, d_white, d_now,
                                  input logic [CFG_DATA_W-1:0] d_old, d_clamp);
    cfg_write(REG_THR_BLACK, d_black);
    cfg_write(REG_THR_WHITE, d_white);
    // unmapped index in the middle: must not disturb anything
    cfg_write(CFG_IDX_W'($urandom_range(REG_UNMAPPED, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_write(REG_GAIN_NEW, d_now);
    cfg_write(REG_GAIN_PREV, d_old);
    cfg_write(REG_MAX_REFLECT, d_clamp);
    cfg_we <= 1'b0;
  endtask

  task automatic program_random();
    logic [SAMPLE_W-1:0] thr_b, thr_w, clamp;
    logic [GAIN_W-1:0]   g_now, g_old;
    if ($urandom_range(0, 4) == 0) begin
      thr_b = SAMPLE_W'($urandom);
      thr_w = SAMPLE_W'($urandom);
    end else begin
      thr_b = SAMPLE_W'($urandom_range(0, 400));
      thr_w = thr_b + SAMPLE_W'($urandom_range(0, 400));
    end
    clamp = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom)
                                         : SAMPLE_W'($urandom_range(thr_w, SAMPLE_MAX));
    g_now = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 32768));
    g_old = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 32768));
    // upper data bits of the 10-bit registers are don't-care
    program_settings({6'($urandom), thr_b}, {6'($urandom), thr_w}, g_now, g_old,
                     {6'($urandom), clamp});
  endtask

  function automatic int unsigned pick_target(level_pick_e pick);
    int unsigned tb_lo, tw_hi;
    tb_lo = sb.thr_black;
    tw_hi = sb.thr_white;
    case (pick)
      LVL_BLACK:    return (tb_lo == 0) ? 0 : $urandom_range(0, tb_lo - 1);
      LVL_AT_BLACK: return tb_lo;
      LVL_GRAY:     return (tw_hi > tb_lo + 1) ? $urandom_range(tb_lo + 1, tw_hi - 1) : tb_lo;
      LVL_AT_WHITE: return tw_hi;
      LVL_WHITE:    return (tw_hi == SAMPLE_MAX) ? SAMPLE_MAX
                                                 : $urandom_range(tw_hi + 1, SAMPLE_MAX);
      LVL_AT_CLAMP: return sb.clamp;
      default:      return $urandom_range(0, SAMPLE_MAX);
    endcase
  endfunction

  // runs of samples aimed at one region, so whole windows go white/gray/black
  task automatic send_random(input int unsigned count);
    level_pick_e         pick;
    int unsigned         run_left, t, d, lo, hi;
    logic [SAMPLE_W-1:0] g, b;
    run_left = 0;
    pick     = LVL_ANY;
    repeat (count) begin
      if (run_left == 0) begin
        pick     = level_pick_e'($urandom_range(LVL_ANY, LVL_AT_CLAMP));
        run_left = $urandom_range(1, 12);
        gaps_on  = ($urandom_range(0, 2) != 0);
      end
      run_left--;
      if (pick == LVL_ANY || $urandom_range(0, 9) == 0) begin
        g = SAMPLE_W'($urandom);
        b = SAMPLE_W'($urandom);
      end else begin
        t  = pick_target(pick);
        d  = $urandom_range(0, (t < SAMPLE_MAX - t) ? t : SAMPLE_MAX - t);
        lo = t - d;
        hi = t + d;
        if (hi < SAMPLE_MAX && $urandom_range(0, 1) == 1) hi++;
        if ($urandom_range(0, 1) == 1) begin
          g = SAMPLE_W'(lo);
          b = SAMPLE_W'(hi);
        end else begin
          g = SAMPLE_W'(hi);
          b = SAMPLE_W'(lo);
        end
      end
      send_sample(SAMPLE_W'($urandom), g, b);
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zeroed window, rounding, clamp, samples on thresholds
    send_sample(10'd0,    10'd0,    10'd0);
    send_sample(10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd0,    10'd1023, 10'd0);
    send_sample(10'd0,    10'd0,    10'd1023);
    send_sample(10'd1023, 10'd0,    10'd1);
    send_sample(10'd0,    10'd80,   10'd0);
    send_sample(10'd0,    10'd79,   10'd2);
    send_sample(10'd0,    10'd240,  10'd0);
    send_sample(10'd0,    10'd121,  10'd120);
    send_sample(10'd0,    10'd78,   10'd0);
    send_sample(10'd0,    10'd82,   10'd0);
    send_sample(10'd0,    10'd238,  10'd1);
    send_sample(10'd0,    10'd242,  10'd0);
    send_sample(10'h2aa,  10'h155,  10'h2aa);
    // fill the window above the white threshold
    repeat (WINDOW_DEPTH) send_sample(10'h155, 10'd1023, 10'd1023);
    send_sample(10'd1023, 10'd401,  10'd400);
    wait_drained();

    // nothing counts black or white; unity pass-through filter
    program_settings(16'd0, 16'd1023, 16'd32768, 16'd0, 16'd1023);
    send_random(PHASE_ITEMS);
    wait_drained();

    // crossed thresholds, largest gains drive saturation
    program_settings(16'd1023, 16'd0, 16'hffff, 16'hffff, 16'd1023);
    send_random(PHASE_ITEMS);
    wait_drained();

    // equal thresholds, zero clamp, pure hold of the previous level
    program_settings(16'hfc64, 16'd100, 16'd0, 16'd32768, 16'd0);
    send_random(PHASE_ITEMS);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p == 8) quiet_tail = 1'b1;
      program_random();
      send_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_stall
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
        @(posedge clk_i);
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall)
        sb.check_reading(brightness_o, filtered_level_o, line_color_o);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
